// File: rtl/upn_pkg.sv
// upn_pkg: shared constants, byte codes and controller/datapath interface types
// for the url path normalizer; no dependencies, compiled first
package upn_pkg;

  // sizes of the normalized byte buffer and the segment-start stack
  localparam int PathBytes = 1024;
  localparam int MaxDepth  = 256;

  localparam int AddrW    = $clog2(PathBytes);
  localparam int PosW     = AddrW + 1;
  localparam int SegAddrW = $clog2(MaxDepth);
  localparam int DepthW   = $clog2(MaxDepth + 1);

  // fixed field widths
  localparam int ByteW    = 8;
  localparam int LimitW   = 11;
  localparam int LenW     = 10;
  localparam int LenMax   = 1023;
  localparam int InDataW  = 8;
  localparam int OutDataW = 24;
  localparam int OutPadW  = OutDataW - 1 - LenW - ByteW;

  localparam logic [LimitW-1:0] LimitReset = 11'd1024;

  // byte codes
  localparam logic [ByteW-1:0] CharSlash = 8'h2F;
  localparam logic [ByteW-1:0] CharDot   = 8'h2E;
  localparam logic [ByteW-1:0] CharNul   = 8'h00;

  // operation, result kind and status codes
  localparam logic OpFeed      = 1'b0;
  localparam logic OpRead      = 1'b1;
  localparam logic KindSummary = 1'b0;
  localparam logic KindData    = 1'b1;
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusBad   = 1'b1;

  // class of the latched feed byte
  typedef enum logic [1:0] {
    BC_SKIP,
    BC_BAD,
    BC_SLASH,
    BC_CHAR
  } upn_class_t;

  // controller to datapath
  typedef struct packed {
    logic feed_start;
    logic rd_start;
    logic set_invalid;
    logic put_slash;
    logic put_char;
    logic close_seg;
    logic pop_load;
    logic finish;
    logic emit;
  } upn_cmd_t;

  // datapath to controller
  typedef struct packed {
    upn_class_t cls;
    logic       seg_open;
    logic       close_pop;
    logic       invalid;
    logic       item_end;
    logic       rd_avail;
    logic       out_free;
  } upn_status_t;

endpackage

// File: rtl/upn_ctrl.sv
// upn_ctrl: sequencing state machine of the url path normalizer
// depends on upn_pkg; drives upn_datapath through upn_cmd_t
module upn_ctrl import upn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_op,
  output logic        in_ready,
  input  upn_status_t status,
  output upn_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_FEED      = 7'b0000010,
    S_PUT_CHAR  = 7'b0000100,
    S_POP       = 7'b0001000,
    S_CLOSE_END = 7'b0010000,
    S_FINISH    = 7'b0100000,
    S_EMIT      = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_byte;

  assign in_ready = (state == S_IDLE);

  // where a feed byte goes once its own work is done
  assign after_byte = status.item_end ? S_CLOSE_END : S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OpRead) begin
            if (status.rd_avail) begin
              cmd.rd_start = 1'b1;
              state_next   = S_EMIT;
            end
          end else begin
            cmd.feed_start = 1'b1;
            state_next     = S_FEED;
          end
        end
      end
      S_FEED: begin
        case (status.cls)
          BC_SKIP: begin
            state_next = after_byte;
          end
          BC_BAD: begin
            cmd.set_invalid = 1'b1;
            state_next      = after_byte;
          end
          BC_SLASH: begin
            cmd.close_seg = 1'b1;
            state_next    = status.close_pop ? S_POP : after_byte;
          end
          BC_CHAR: begin
            if (!status.seg_open) begin
              cmd.put_slash = 1'b1;
              state_next    = S_PUT_CHAR;
            end else begin
              cmd.put_char = 1'b1;
              state_next   = after_byte;
            end
          end
          default: begin
            state_next = after_byte;
          end
        endcase
      end
      S_PUT_CHAR: begin
        cmd.put_char = 1'b1;
        state_next   = after_byte;
      end
      S_POP: begin
        // a second visit to the final close finds no open segment
        cmd.pop_load = 1'b1;
        state_next   = after_byte;
      end
      S_CLOSE_END: begin
        if (!status.invalid && status.seg_open) begin
          cmd.close_seg = 1'b1;
          state_next    = status.close_pop ? S_POP : S_FINISH;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // once a feed word is taken, the input is not ready while its byte is worked on
  a_feed_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_op == OpFeed) |=> !in_ready)
    else $error("input taken right after a feed word");

  // a result is only handed over when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("emit while output register busy");
`endif

endmodule

// File: rtl/upn_datapath.sv
// upn_datapath: segment state, byte buffer, segment-start stack, config register
// and output register of the url path normalizer; depends on upn_pkg
module upn_datapath import upn_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  upn_cmd_t            cmd,
  output upn_status_t         status,
  input  logic [ByteW-1:0]    in_byte,
  input  logic                in_end,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LimitW-1:0]   cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OutDataW-1:0] out_data,
  output logic                out_kind,
  output logic                out_last
);

  // running path state
  logic [DepthW-1:0] depth;
  logic [PosW-1:0]   wp;
  logic [PosW-1:0]   seglen;
  logic [1:0]        dots;
  logic [PosW-1:0]   seen;
  logic              invalid;
  logic [PosW-1:0]   read_pos;
  logic [LimitW-1:0] out_limit;

  // latched item and result payload
  logic [ByteW-1:0]  item_byte;
  logic              item_end;
  logic              item_first;
  logic              item_proc;
  logic              emit_read;
  logic              sum_status;
  logic [LenW-1:0]   sum_len;

  // memories and their read registers
  logic [ByteW-1:0]  byte_mem [PathBytes];
  logic [AddrW-1:0]  seg_mem  [MaxDepth];
  logic [ByteW-1:0]  rd_byte;
  logic [AddrW-1:0]  seg_rd;

  // decode of the open segment
  logic              seg_open;
  logic              single_dot;
  logic              double_dot;
  logic              push_ok;
  logic              wp_room;
  logic [PosW-1:0]   open_base;
  logic [DepthW-1:0] depth_dec;
  logic [PosW-1:0]   fin_len;
  logic              fin_bad;
  upn_class_t        cls;

  // buffer write port
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [ByteW-1:0]  wr_data;

  assign cfg_ready  = 1'b1;
  assign seg_open   = (seglen != '0);
  assign single_dot = (seglen == PosW'(1)) && dots[0];
  assign double_dot = (seglen == PosW'(2)) && (dots == 2'b11);
  assign depth_dec  = depth - DepthW'(1);
  assign push_ok    = cmd.close_seg && seg_open && !single_dot && !double_dot
                      && (depth < DepthW'(MaxDepth));
  assign wp_room    = (wp < PosW'(PathBytes));
  assign open_base  = wp - seglen - PosW'(1);

  // summary length check against the output limit register and LenMax
  assign fin_len = (depth == '0) ? PosW'(1) : wp;
  assign fin_bad = invalid || (int'(fin_len) >= int'(out_limit)) || (int'(fin_len) > LenMax);

  // byte class
  always_comb begin
    if (!item_proc) begin
      cls = BC_SKIP;
    end else if ((item_first && item_byte != CharSlash) || item_byte == CharNul) begin
      cls = BC_BAD;
    end else if (item_byte == CharSlash) begin
      cls = BC_SLASH;
    end else begin
      cls = BC_CHAR;
    end
  end

  assign status.cls       = cls;
  assign status.seg_open  = seg_open;
  assign status.close_pop = seg_open && double_dot && (depth != '0);
  assign status.invalid   = invalid;
  assign status.item_end  = item_end;
  assign status.rd_avail  = (seen == '0) && (read_pos < wp) && (read_pos < PosW'(PathBytes));
  assign status.out_free  = !out_valid || out_ready;

  // buffer write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wp[AddrW-1:0];
    wr_data = item_byte;
    if (cmd.put_slash && wp_room) begin
      wr_en   = 1'b1;
      wr_data = CharSlash;
    end else if (cmd.put_char && wp_room) begin
      wr_en   = 1'b1;
    end else if (cmd.finish && !invalid && depth == '0) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = CharSlash;
    end
  end

  // normalized byte buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_start) begin
      rd_byte <= byte_mem[read_pos[AddrW-1:0]];
    end
  end

  // segment-start stack
  always_ff @(posedge clk) begin
    if (push_ok) begin
      seg_mem[depth[SegAddrW-1:0]] <= open_base[AddrW-1:0];
    end
    if (cmd.close_seg && status.close_pop) begin
      seg_rd <= seg_mem[depth_dec[SegAddrW-1:0]];
    end
  end

  // path state
  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      wp        <= '0;
      seglen    <= '0;
      dots      <= '0;
      seen      <= '0;
      invalid   <= 1'b0;
      read_pos  <= '0;
      out_limit <= LimitReset;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        out_limit <= cfg_data;
      end
      // new path starts on the first feed word after a summary
      if (cmd.feed_start) begin
        if (seen == '0) begin
          depth    <= '0;
          wp       <= '0;
          seglen   <= '0;
          dots     <= '0;
          invalid  <= 1'b0;
          read_pos <= '0;
        end
        if (seen >= PosW'(PathBytes)) begin
          invalid <= 1'b1;
        end else begin
          seen <= seen + PosW'(1);
        end
      end
      if (cmd.set_invalid) begin
        invalid <= 1'b1;
      end
      // byte appended to the buffer
      if (cmd.put_slash || cmd.put_char) begin
        if (wp_room) begin
          wp <= wp + PosW'(1);
        end else begin
          invalid <= 1'b1;
        end
      end
      if (cmd.put_char) begin
        if (seglen < PosW'(2) && item_byte == CharDot) begin
          dots <= dots | (2'b01 << seglen[0]);
        end
        seglen <= seglen + PosW'(1);
      end
      // segment close: drop '.', pop on '..' (invalid at root), else push its start (invalid when full)
      if (cmd.close_seg && seg_open) begin
        if (single_dot) begin
          wp <= wp - PosW'(2);
        end else if (double_dot) begin
          if (depth == '0) begin
            invalid <= 1'b1;
          end else begin
            depth <= depth_dec;
          end
        end else if (!push_ok) begin
          invalid <= 1'b1;
        end else begin
          depth <= depth + DepthW'(1);
        end
        seglen <= '0;
        dots   <= '0;
      end
      if (cmd.pop_load) begin
        wp <= {1'b0, seg_rd};
      end
      // summary: fix the readable length
      if (cmd.finish) begin
        seen     <= '0;
        read_pos <= '0;
        invalid  <= fin_bad;
        wp       <= fin_bad ? '0 : fin_len;
      end
      if (cmd.emit && emit_read) begin
        read_pos <= read_pos + PosW'(1);
      end
      // output register handshake
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.feed_start) begin
      item_byte  <= in_byte;
      item_end   <= in_end;
      item_first <= (seen == '0);
      item_proc  <= (seen < PosW'(PathBytes)) && ((seen == '0) || !invalid);
    end
    if (cmd.rd_start) begin
      emit_read <= 1'b1;
    end
    if (cmd.finish) begin
      emit_read  <= 1'b0;
      sum_status <= fin_bad ? StatusBad : StatusOk;
      sum_len    <= fin_bad ? '0 : LenW'(fin_len);
    end
    if (cmd.emit) begin
      if (emit_read) begin
        out_kind <= KindData;
        out_data <= {{OutPadW{1'b0}}, rd_byte, {LenW{1'b0}}, StatusOk};
        out_last <= (read_pos + PosW'(1) == wp);
      end else begin
        out_kind <= KindSummary;
        out_data <= {{OutPadW{1'b0}}, {ByteW{1'b0}}, sum_len, sum_status};
        out_last <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // between paths the read pointer never passes the readable length
  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (seen == '0) |-> (read_pos <= wp))
    else $error("read pointer beyond normalized length");

  // segment stack never overfills
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DepthW'(MaxDepth))
    else $error("segment depth beyond stack size");

  // an invalid summary reports zero length
  a_bad_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KindSummary && out_data[0] == StatusBad)
      |-> (out_data[LenW:1] == '0))
    else $error("invalid summary with nonzero length");
`endif

endmodule

// File: rtl/url_path_normalizer_unit.sv
// url_path_normalizer_unit: top level of the url path normalizer
// depends on upn_pkg, upn_ctrl and upn_datapath
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tuser operation, tdata path_byte, tlast path_end
//  m_axis   out  m_axis_tvalid/tready       tuser kind, tdata status/length/byte, tlast final
//  cfg      in   cfg_valid/cfg_ready        cfg_data out_limit
//
// a feed word passes through the feed step, a put-char step when it opens a segment,
// and a pop step for a '..' pop, which reads the segment-start stack; the last word
// adds close, finish and emit steps (and a pop and a second close when the final close
// pops). a read word goes to emit after the buffer read; one with nothing to return gives no result.
// reset is synchronous; the byte buffer and segment stack are not cleared.
// a result waits in the output register; the unit holds in its emit step until taken.
module url_path_normalizer_unit import upn_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] path_byte
  input  logic                s_axis_tuser,   // [0] operation
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [0] status, [10:1] norm_length, [18:11] out_byte
  output logic                m_axis_tuser,   // [0] kind
  output logic                m_axis_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LimitW-1:0]   cfg_data
);

  upn_cmd_t    cmd;
  upn_status_t status;

  // sequencer
  upn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  upn_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (s_axis_tdata),
    .in_end    (s_axis_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule
